// ----- rtl/core/ltcp_pkg.sv -----
`timescale 1ns / 1ps
package ltcp_pkg;

    localparam int LINE_LIMIT_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] CHAR_L   = 8'h4C;
    localparam logic [7:0] CHAR_S   = 8'h53;
    localparam logic [7:0] CHAR_O   = 8'h4F;
    localparam logic [7:0] CHAR_N   = 8'h4E;

    typedef enum logic [1:0] {
        KIND_ECHO    = 2'd0,
        KIND_EXEC    = 2'd1,
        KIND_INVALID = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef struct packed {
        logic       is_button;
        logic [7:0] ch;
        logic       ends_line;
        logic       cmd_ok;
        logic [6:0] led_number;
        logic       led_on;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // "LED:"
    function automatic logic [7:0] led_key_char(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = 8'h4C;
            2'd1: r = 8'h45;
            2'd2: r = 8'h44;
            2'd3: r = 8'h3A;
        endcase
        return r;
    endfunction

    // "STATE:"
    function automatic logic [7:0] state_key_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h53;
            3'd1:    r = 8'h54;
            3'd2:    r = 8'h41;
            3'd3:    r = 8'h54;
            3'd4:    r = 8'h45;
            3'd5:    r = 8'h3A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_0) && (c <= CHAR_9);
    endfunction

endpackage

// ----- rtl/core/ltcp_front.sv -----
`timescale 1ns / 1ps
module ltcp_front #(
    parameter int LINE_LIMIT = ltcp_pkg::LINE_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                op,
    input  logic [7:0]          rx_byte,
    input  ltcp_pkg::q_status_t q_status,
    output logic                push,
    output ltcp_pkg::cmd_t      cmd
);

    localparam int LC_W = $clog2(LINE_LIMIT - 1);

    logic [LC_W-1:0] line_count_reg, line_count_next;
    logic            nul_reg, nul_next;
    logic [1:0]      led_prog_reg, led_prog_next;
    logic            led_found_reg, led_found_next;
    logic [1:0]      led_cnt_reg, led_cnt_next;
    logic [7:0]      led_d0_reg, led_d0_next;
    logic [7:0]      led_d1_reg, led_d1_next;
    logic [2:0]      st_prog_reg, st_prog_next;
    logic            st_found_reg, st_found_next;
    logic [1:0]      st_cnt_reg, st_cnt_next;
    logic [7:0]      st_b0_reg, st_b0_next;
    logic [7:0]      st_b1_reg, st_b1_next;

    logic       is_term;
    logic       at_limit;
    logic       line_end;
    logic [2:0] led_step;
    logic [2:0] st_step;
    logic       num_ok;
    logic       on_dec;
    logic [6:0] num_dec;

    assign push     = in_valid && !q_status.full;
    assign is_term  = (rx_byte == ltcp_pkg::CHAR_CR) || (rx_byte == ltcp_pkg::CHAR_LF);
    assign at_limit = (line_count_reg == LC_W'(LINE_LIMIT - 2));
    assign line_end = !op && (is_term || at_limit);

    always_comb
    begin
        led_step = (rx_byte == ltcp_pkg::led_key_char(led_prog_reg))
                 ? ({1'b0, led_prog_reg} + 3'd1)
                 : ((rx_byte == ltcp_pkg::CHAR_L) ? 3'd1 : 3'd0);
        st_step  = (rx_byte == ltcp_pkg::state_key_char(st_prog_reg))
                 ? (st_prog_reg + 3'd1)
                 : ((rx_byte == ltcp_pkg::CHAR_S) ? 3'd1 : 3'd0);
    end

    // line state after this byte is fed to the matchers
    always_comb
    begin
        nul_next       = nul_reg;
        led_prog_next  = led_prog_reg;
        led_found_next = led_found_reg;
        led_cnt_next   = led_cnt_reg;
        led_d0_next    = led_d0_reg;
        led_d1_next    = led_d1_reg;
        st_prog_next   = st_prog_reg;
        st_found_next  = st_found_reg;
        st_cnt_next    = st_cnt_reg;
        st_b0_next     = st_b0_reg;
        st_b1_next     = st_b1_reg;
        if (!op && !is_term && !nul_reg)
        begin
            if (rx_byte == ltcp_pkg::CHAR_NUL)
            begin
                nul_next = 1'b1;
            end
            else
            begin
                if (led_found_reg)
                begin
                    if (led_cnt_reg == 2'd0)
                    begin
                        led_d0_next  = rx_byte;
                        led_cnt_next = 2'd1;
                    end
                    else if (led_cnt_reg == 2'd1)
                    begin
                        led_d1_next  = rx_byte;
                        led_cnt_next = 2'd2;
                    end
                end
                else if (led_step == 3'd4)
                begin
                    led_found_next = 1'b1;
                    led_prog_next  = 2'd0;
                end
                else
                begin
                    led_prog_next = led_step[1:0];
                end

                if (st_found_reg)
                begin
                    if (st_cnt_reg == 2'd0)
                    begin
                        st_b0_next  = rx_byte;
                        st_cnt_next = 2'd1;
                    end
                    else if (st_cnt_reg == 2'd1)
                    begin
                        st_b1_next  = rx_byte;
                        st_cnt_next = 2'd2;
                    end
                end
                else if (st_step == 3'd6)
                begin
                    st_found_next = 1'b1;
                    st_prog_next  = 3'd0;
                end
                else
                begin
                    st_prog_next = st_step;
                end
            end
        end
        line_count_next = line_count_reg + LC_W'(1);
    end

    always_comb
    begin
        num_ok  = (led_cnt_next == 2'd2) && ltcp_pkg::is_digit(led_d0_next)
               && ltcp_pkg::is_digit(led_d1_next);
        num_dec = num_ok ? (7'(led_d0_next[3:0]) * 7'd10 + 7'(led_d1_next[3:0])) : 7'd0;
        on_dec  = (st_cnt_next == 2'd2) && (st_b0_next == ltcp_pkg::CHAR_O)
               && (st_b1_next == ltcp_pkg::CHAR_N);

        cmd.is_button  = op;
        cmd.ch         = rx_byte;
        cmd.ends_line  = line_end;
        cmd.cmd_ok     = led_found_next && st_found_next;
        cmd.led_number = (led_found_next && st_found_next) ? num_dec : 7'd0;
        cmd.led_on     = led_found_next && st_found_next && on_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            nul_reg        <= 1'b0;
            led_prog_reg   <= 2'd0;
            led_found_reg  <= 1'b0;
            led_cnt_reg    <= 2'd0;
            led_d0_reg     <= 8'd0;
            led_d1_reg     <= 8'd0;
            st_prog_reg    <= 3'd0;
            st_found_reg   <= 1'b0;
            st_cnt_reg     <= 2'd0;
            st_b0_reg      <= 8'd0;
            st_b1_reg      <= 8'd0;
        end
        else if (push && !op)
        begin
            if (line_end)
            begin
                line_count_reg <= '0;
                nul_reg        <= 1'b0;
                led_prog_reg   <= 2'd0;
                led_found_reg  <= 1'b0;
                led_cnt_reg    <= 2'd0;
                st_prog_reg    <= 3'd0;
                st_found_reg   <= 1'b0;
                st_cnt_reg     <= 2'd0;
            end
            else
            begin
                line_count_reg <= line_count_next;
                nul_reg        <= nul_next;
                led_prog_reg   <= led_prog_next;
                led_found_reg  <= led_found_next;
                led_cnt_reg    <= led_cnt_next;
                led_d0_reg     <= led_d0_next;
                led_d1_reg     <= led_d1_next;
                st_prog_reg    <= st_prog_next;
                st_found_reg   <= st_found_next;
                st_cnt_reg     <= st_cnt_next;
                st_b0_reg      <= st_b0_next;
                st_b1_reg      <= st_b1_next;
            end
        end
    end

endmodule

// ----- rtl/core/ltcp_queue.sv -----
`timescale 1ns / 1ps
module ltcp_queue #(
    parameter int DEPTH = ltcp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ltcp_pkg::cmd_t      wr_cmd,
    input  logic                pop,
    output ltcp_pkg::cmd_t      head,
    output ltcp_pkg::q_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ltcp_pkg::cmd_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- rtl/core/ltcp_back.sv -----
`timescale 1ns / 1ps
module ltcp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ltcp_pkg::cmd_t      head,
    input  ltcp_pkg::q_status_t q_status,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [1:0]          kind,
    output logic [7:0]          echo_byte,
    output logic [6:0]          led_number,
    output logic                led_on,
    output logic [2:0]          led_levels,
    output logic                last
);

    typedef enum logic {
        PH_ECHO,
        PH_FINISH
    } phase_t;

    phase_t          phase_reg;
    logic            out_valid_reg;
    ltcp_pkg::kind_t kind_reg;
    logic [7:0]      echo_reg;
    logic [6:0]      number_reg;
    logic            on_reg;
    logic [2:0]      levels_reg;
    logic            last_reg;
    logic [2:0]      led_reg;

    logic       load;
    logic       take;
    logic       hit;
    logic [2:0] bit_mask;
    logic [2:0] led_applied;

    assign load = !out_valid_reg || !out_stall;
    assign take = load && !q_status.empty;
    assign pop  = take && (head.is_button || (phase_reg == PH_FINISH) || !head.ends_line);

    always_comb
    begin
        hit      = head.cmd_ok && (head.led_number >= 7'd1) && (head.led_number <= 7'd3);
        bit_mask = 3'd0;
        unique case (head.led_number[1:0])
            2'd1:    bit_mask = 3'b001;
            2'd2:    bit_mask = 3'b010;
            2'd3:    bit_mask = 3'b100;
            default: bit_mask = 3'b000;
        endcase
        led_applied = led_reg;
        if (hit)
        begin
            led_applied = head.led_on ? (led_reg | bit_mask) : (led_reg & ~bit_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ECHO;
            out_valid_reg <= 1'b0;
            kind_reg      <= ltcp_pkg::KIND_ECHO;
            echo_reg      <= 8'd0;
            number_reg    <= 7'd0;
            on_reg        <= 1'b0;
            levels_reg    <= 3'b111;
            last_reg      <= 1'b0;
            led_reg       <= 3'b111;
        end
        else if (load)
        begin
            out_valid_reg <= !q_status.empty;
            if (take)
            begin
                if (head.is_button)
                begin
                    kind_reg   <= ltcp_pkg::KIND_CLEAR;
                    echo_reg   <= 8'd0;
                    number_reg <= 7'd0;
                    on_reg     <= 1'b0;
                    levels_reg <= 3'b000;
                    last_reg   <= 1'b1;
                    led_reg    <= 3'b000;
                end
                else if (phase_reg == PH_ECHO)
                begin
                    kind_reg   <= ltcp_pkg::KIND_ECHO;
                    echo_reg   <= head.ch;
                    number_reg <= 7'd0;
                    on_reg     <= 1'b0;
                    levels_reg <= led_reg;
                    last_reg   <= !head.ends_line;
                    if (head.ends_line)
                    begin
                        phase_reg <= PH_FINISH;
                    end
                end
                else
                begin
                    kind_reg   <= head.cmd_ok ? ltcp_pkg::KIND_EXEC : ltcp_pkg::KIND_INVALID;
                    echo_reg   <= 8'd0;
                    number_reg <= head.led_number;
                    on_reg     <= head.led_on;
                    levels_reg <= led_applied;
                    last_reg   <= 1'b1;
                    led_reg    <= led_applied;
                    phase_reg  <= PH_ECHO;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign echo_byte  = echo_reg;
    assign led_number = number_reg;
    assign led_on     = on_reg;
    assign led_levels = levels_reg;
    assign last       = last_reg;

endmodule

// ----- rtl/core/led_text_command_parser_unit.sv -----
`timescale 1ns / 1ps
// path: inputs pass through the command queue into the registered outputs
// throughput: one input per clock unless in_stall; one result per clock unless
// out_stall; a line-ending byte yields two results, buffered by the command queue
// reset: asynchronous active-low; LEDs on, line state and queue empty
module led_text_command_parser_unit #(
    parameter int LINE_LIMIT  = ltcp_pkg::LINE_LIMIT_DEF,
    parameter int QUEUE_DEPTH = ltcp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] echo_byte,
    output logic [6:0] led_number,
    output logic       led_on,
    output logic [2:0] led_levels,
    output logic       last
);

    ltcp_pkg::q_status_t q_status;
    ltcp_pkg::cmd_t      wr_cmd;
    ltcp_pkg::cmd_t      head;
    logic                push;
    logic                pop;

    assign in_stall = q_status.full;

    ltcp_front #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push),
        .cmd      (wr_cmd)
    );

    ltcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    ltcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .kind       (kind),
        .echo_byte  (echo_byte),
        .led_number (led_number),
        .led_on     (led_on),
        .led_levels (led_levels),
        .last       (last)
    );

`ifndef ASSERT_OFF
    a_finish_follows_echo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (kind == ltcp_pkg::KIND_ECHO) && !last
        |=> out_valid && ((kind == ltcp_pkg::KIND_EXEC) || (kind == ltcp_pkg::KIND_INVALID)))
        else $error("line end transaction not followed by its command result");

    a_non_echo_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != ltcp_pkg::KIND_ECHO) |-> last && (echo_byte == 8'd0))
        else $error("command or clear result not marked last");

    a_clear_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == ltcp_pkg::KIND_CLEAR) |-> (led_levels == 3'b000))
        else $error("button clear left an LED on");

    a_no_decode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != ltcp_pkg::KIND_EXEC) |-> (led_number == 7'd0) && !led_on)
        else $error("decoded fields set on a non-command result");
`endif

endmodule

// ----- sim/led_text_command_parser_unit_tb.sv -----
`timescale 1ns / 1ps
module led_text_command_parser_unit_tb;

    localparam int LINE_MAX    = ltcp_pkg::LINE_LIMIT_DEF - 1;
    localparam int ITEM_GOAL   = 550;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int REPORT_MAX  = 10;

    localparam logic [31:0] LED_WORD   = "LED:";
    localparam logic [47:0] STATE_WORD = "STATE:";

    typedef struct packed {
        ltcp_pkg::kind_t kind;
        logic [7:0]      echo;
        logic [6:0]      num;
        logic            on;
        logic [2:0]      levels;
        logic            lst;
    } result_t;

    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } rx_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       op        = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] kind;
    logic [7:0] echo_byte;
    logic [6:0] led_number;
    logic       led_on;
    logic [2:0] led_levels;
    logic       last;

    // predicted parser state
    logic [2:0] led_lvl  = 3'b111;
    int         line_len = 0;
    logic       nul_flag = 1'b0;
    int         led_prog = 0;
    logic       led_hit  = 1'b0;
    int         led_n    = 0;
    logic [7:0] led_ch [2];
    int         st_prog  = 0;
    logic       st_hit   = 1'b0;
    int         st_n     = 0;
    logic [7:0] st_ch [2];

    result_t    pending_results [$];
    logic [7:0] line_buf [$];
    string      junk_set = "LSTEAD:ON09 x";

    result_t  got_r;
    result_t  want_r;
    rx_mode_t rx_mode     = RX_OPEN;
    int       mode_left   = 0;
    int       hold_req    = 0;
    int       hold_left   = 0;
    int       burst_left  = 0;
    bit       no_gaps     = 1'b0;
    int       idle_cycles = 0;

    int items_sent   = 0;
    int buttons      = 0;
    int results_seen = 0;
    int lines_closed = 0;
    int cmds_run     = 0;
    int fail_cnt     = 0;

    led_text_command_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .echo_byte  (echo_byte),
        .led_number (led_number),
        .led_on     (led_on),
        .led_levels (led_levels),
        .last       (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic push_result(input ltcp_pkg::kind_t k, input logic [7:0] e,
                               input logic [6:0] n, input logic on_v, input logic lst);
        result_t r;
        r.kind   = k;
        r.echo   = e;
        r.num    = n;
        r.on     = on_v;
        r.levels = led_lvl;
        r.lst    = lst;
        pending_results.push_back(r);
    endtask

    task automatic close_line;
        int   num;
        logic on_v;
        num  = 0;
        on_v = 1'b0;
        if (led_hit && st_hit)
        begin
            if (led_n >= 2 && led_ch[0] >= ltcp_pkg::CHAR_0 && led_ch[0] <= ltcp_pkg::CHAR_9 &&
                led_ch[1] >= ltcp_pkg::CHAR_0 && led_ch[1] <= ltcp_pkg::CHAR_9)
                num = (led_ch[0] - ltcp_pkg::CHAR_0) * 10 + (led_ch[1] - ltcp_pkg::CHAR_0);
            if (st_n >= 2 && st_ch[0] == ltcp_pkg::CHAR_O && st_ch[1] == ltcp_pkg::CHAR_N)
                on_v = 1'b1;
            if (num >= 1 && num <= 3)
                led_lvl[num - 1] = on_v;
            push_result(ltcp_pkg::KIND_EXEC, 8'h00, num[6:0], on_v, 1'b1);
            cmds_run++;
        end
        else
            push_result(ltcp_pkg::KIND_INVALID, 8'h00, 7'd0, 1'b0, 1'b1);
        lines_closed++;
        line_len = 0;
        nul_flag = 1'b0;
        led_prog = 0;
        led_hit  = 1'b0;
        led_n    = 0;
        st_prog  = 0;
        st_hit   = 1'b0;
        st_n     = 0;
    endtask

    // expected results of one accepted transaction
    task automatic predict_parse(input logic o, input logic [7:0] c);
        if (o)
        begin
            led_lvl = 3'b000;
            push_result(ltcp_pkg::KIND_CLEAR, 8'h00, 7'd0, 1'b0, 1'b1);
            buttons++;
            return;
        end
        if (c == ltcp_pkg::CHAR_CR || c == ltcp_pkg::CHAR_LF)
        begin
            push_result(ltcp_pkg::KIND_ECHO, c, 7'd0, 1'b0, 1'b0);
            close_line();
            return;
        end
        if (!nul_flag)
        begin
            if (c == ltcp_pkg::CHAR_NUL)
                nul_flag = 1'b1;
            else
            begin
                if (led_hit)
                begin
                    if (led_n < 2)
                    begin
                        led_ch[led_n] = c;
                        led_n++;
                    end
                end
                else
                begin
                    if (c == LED_WORD[31 - 8 * led_prog -: 8])
                        led_prog++;
                    else
                        led_prog = (c == ltcp_pkg::CHAR_L) ? 1 : 0;
                    if (led_prog == 4)
                    begin
                        led_hit  = 1'b1;
                        led_prog = 0;
                    end
                end
                if (st_hit)
                begin
                    if (st_n < 2)
                    begin
                        st_ch[st_n] = c;
                        st_n++;
                    end
                end
                else
                begin
                    if (c == STATE_WORD[47 - 8 * st_prog -: 8])
                        st_prog++;
                    else
                        st_prog = (c == ltcp_pkg::CHAR_S) ? 1 : 0;
                    if (st_prog == 6)
                    begin
                        st_hit  = 1'b1;
                        st_prog = 0;
                    end
                end
            end
        end
        line_len++;
        if (line_len >= LINE_MAX)
        begin
            push_result(ltcp_pkg::KIND_ECHO, c, 7'd0, 1'b0, 1'b0);
            close_line();
        end
        else
            push_result(ltcp_pkg::KIND_ECHO, c, 7'd0, 1'b0, 1'b1);
    endtask

    task automatic pace;
        int gap;
        if (no_gaps)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            op       <= 1'($urandom);
            rx_byte  <= 8'($urandom);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 20);
        end
    endtask

    // called at a rising edge; ends after the edge that took the transaction
    task automatic send_item(input logic o, input logic [7:0] c);
        in_valid <= 1'b1;
        op       <= o;
        rx_byte  <= c;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        predict_parse(o, c);
        items_sent++;
        pace();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] junk_byte;
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(1, 255));
        return junk_set[$urandom_range(0, junk_set.len() - 1)];
    endfunction

    task automatic add_led_part;
        if ($urandom_range(0, 11) == 0)
            return;
        push_text("LED:");
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                line_buf.push_back(ltcp_pkg::CHAR_0);
                line_buf.push_back(8'(ltcp_pkg::CHAR_0 + $urandom_range(0, 4)));
            end
            5:
            begin
                line_buf.push_back(8'(ltcp_pkg::CHAR_0 + $urandom_range(0, 9)));
                line_buf.push_back(8'(ltcp_pkg::CHAR_0 + $urandom_range(0, 9)));
            end
            6: line_buf.push_back(8'(ltcp_pkg::CHAR_0 + $urandom_range(0, 9)));
            7:
            begin
                line_buf.push_back(8'(ltcp_pkg::CHAR_0 + $urandom_range(0, 9)));
                line_buf.push_back(junk_byte());
            end
            8: push_text("99");
            default: ;
        endcase
    endtask

    task automatic build_line;
        bit led_first;
        int target;
        line_buf.delete();
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3)) line_buf.push_back(junk_byte());
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) != 0)
                    push_text("LE");
                else
                    push_text("STAT");
            end
            led_first = 1'($urandom_range(0, 1));
            if (led_first)
                add_led_part();
            if ($urandom_range(0, 13) == 0)
                line_buf.push_back(ltcp_pkg::CHAR_NUL);
            if ($urandom_range(0, 2) == 0)
                line_buf.push_back(junk_byte());
            if ($urandom_range(0, 11) != 0)
            begin
                push_text("STATE:");
                case ($urandom_range(0, 5))
                    0, 1: push_text("ON");
                    2: push_text("OFF");
                    3: push_text("On");
                    4: push_text("O");
                    default: push_text("NO");
                endcase
            end
            if ($urandom_range(0, 13) == 0)
                line_buf.push_back(ltcp_pkg::CHAR_NUL);
            if (!led_first)
                add_led_part();
            repeat ($urandom_range(0, 2)) line_buf.push_back(junk_byte());
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: line_buf.push_back(ltcp_pkg::CHAR_CR);
            9, 10, 11, 12, 13, 14, 15, 16, 17: line_buf.push_back(ltcp_pkg::CHAR_LF);
            default:
            begin
                // run to or past the line length limit
                target = LINE_MAX + $urandom_range(0, 3);
                while (line_buf.size() < target)
                    line_buf.push_back(junk_byte());
            end
        endcase
    endtask

    task automatic send_line;
        foreach (line_buf[i])
        begin
            if ($urandom_range(0, 39) == 0)
                send_item(1'b1, 8'($urandom_range(0, 255)));
            send_item(1'b0, line_buf[i]);
        end
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed;
        send_item(1'b1, 8'hFF);
        send_item(1'b0, ltcp_pkg::CHAR_LF);
        send_text("STATE:ONLED:01");
        send_item(1'b0, ltcp_pkg::CHAR_CR);
        send_text("LED:7");
        send_item(1'b0, ltcp_pkg::CHAR_CR);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, ltcp_pkg::CHAR_NUL);
        send_item(1'b0, ltcp_pkg::CHAR_CR);
    endtask

    // output held off while input keeps coming, then a full drain
    task automatic test_backpressure;
        int start;
        start    = items_sent;
        hold_req = HOLD_CYCLES;
        no_gaps  = 1'b1;
        while (items_sent - start < 40)
        begin
            build_line();
            send_line();
        end
        no_gaps = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_lines;
        while (items_sent < ITEM_GOAL)
        begin
            build_line();
            send_line();
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   out_stall <= 1'b0;
                RX_LIGHT:  out_stall <= ($urandom_range(0, 9) < 3);
                RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
                RX_TOGGLE: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_r.kind   = ltcp_pkg::kind_t'(kind);
            got_r.echo   = echo_byte;
            got_r.num    = led_number;
            got_r.on     = led_on;
            got_r.levels = led_levels;
            got_r.lst    = last;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result kind %0d echo %h num %0d leds %b",
                             $time, kind, echo_byte, led_number, led_levels);
            end
            else
            begin
                want_r = pending_results.pop_front();
                if (got_r !== want_r)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display({"%0t: mismatch (exp/got) kind %0d/%0d echo %h/%h ",
                                  "num %0d/%0d on %b/%b leds %b/%b last %b/%b"},
                                 $time, want_r.kind, got_r.kind, want_r.echo, got_r.echo,
                                 want_r.num, got_r.num, want_r.on, got_r.on,
                                 want_r.levels, got_r.levels, want_r.lst, got_r.lst);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("led_text_command_parser_unit_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_lines();
        wait_idle();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            fail_cnt += pending_results.size();
        end
        $display("covered %0d inputs (%0d button presses), %0d results checked",
                 items_sent, buttons, results_seen);
        $display("%0d lines closed, %0d commands run, %0d failures",
                 lines_closed, cmds_run, fail_cnt);
        if (fail_cnt == 0)
            $display("led_text_command_parser_unit_tb: done, clean");
        else
            $display("led_text_command_parser_unit_tb: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ltcp_pkg.sv
rtl/core/ltcp_front.sv
rtl/core/ltcp_queue.sv
rtl/core/ltcp_back.sv
rtl/core/led_text_command_parser_unit.sv
sim/led_text_command_parser_unit_tb.sv
